// ===== hw/rtl/sta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_pkg
// Types, sizes and helpers shared by the session table with aging.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int KEY_W   = 16;
    localparam int USER_W  = 32;
    localparam int TIME_W  = 32;
    localparam int FIELD_W = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_TOUCH  = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_SWEEP  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [KEY_W-1:0]  key;
        logic [USER_W-1:0] user_id;
        logic [TIME_W-1:0] now;
    } sta_in_t;

    typedef struct packed {
        logic               status;
        logic               hit;
        logic [FIELD_W-1:0] occupied;
        logic [FIELD_W-1:0] removed;
    } sta_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [USER_W-1:0] user;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    function automatic logic [FIELD_W-1:0] fit_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_W-1:0] ext;
        ext = {{FIELD_W{1'b0}}, v};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/session_table_with_aging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_table_with_aging
// Session table with idle timeout: add, touch, delete and expiry sweep.
//
//   channel   ports                           transfer
//   input     s_valid / s_ready / s_data      one command
//   result    m_valid / m_ready / m_data      one result per command
//   config    cfg_valid / cfg_ready / cfg_data recycle time, always ready
//
// Each command scans the table with one read per entry on the entry RAM's
// read port before its result is presented.
// One command is in work at a time; s_ready is high only while idle.
// Reset clears all valid bits and the count at once; no clearing pass.
// A stalled result waits in the output register; the next command may be
// taken meanwhile and stalls before its write-back until that slot is free.
// ----------------------------------------------------------------------------
module session_table_with_aging (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sta_pkg::sta_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sta_pkg::sta_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import sta_pkg::*;

    logic [31:0] recycle_reg;
    logic        m_valid_reg, m_valid_next;
    sta_out_t    m_data_reg;

    logic        res_valid;
    logic        res_ready;
    sta_out_t    res;
    ram_req_t    ram_req;
    entry_t      ram_rdata;

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recycle_reg <= 32'd60;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                recycle_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    sta_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_item      (s_data),
        .recycle_time (recycle_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    sta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== hw/rtl/sta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sta_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ctrl
// Command sequencer: scans the entry RAM, tracks valid bits and the entry
// count, and writes back the refreshed or inserted entry.
// ----------------------------------------------------------------------------
module sta_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sta_pkg::sta_in_t          in_item,
    input  logic [31:0]               recycle_time,
    output logic                      res_valid,
    input  logic                      res_ready,
    output sta_pkg::sta_out_t         res,
    output sta_pkg::ram_req_t         ram_req,
    input  sta_pkg::entry_t           ram_rdata
);
    import sta_pkg::*;

    state_t                 state_reg, state_next;
    sta_in_t                item_reg, item_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   match_reg, match_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic [USER_W-1:0]      match_user_reg, match_user_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;

    logic                   issue;
    logic                   cur_valid;
    logic [TIME_W-1:0]      age;
    logic [CNT_W-1:0]       res_count;
    logic [CNT_W-1:0]       res_removed;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_UPDATE);
    assign issue     = (addr_reg < CNT_W'(TABLE_ENTRIES));
    assign cur_valid = valid_reg[pend_idx_reg];
    assign age       = item_reg.now - ram_rdata.stamp;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        addr_next       = addr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_user_next = match_user_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        removed_next    = removed_reg;

        ram_req.we      = 1'b0;
        ram_req.waddr   = match_idx_reg;
        ram_req.wdata   = '{key: item_reg.key, user: item_reg.user_id, stamp: item_reg.now};
        ram_req.raddr   = addr_reg[IDX_W-1:0];

        res_count       = count_reg;
        res_removed     = '0;
        res.status      = 1'b0;
        res.hit         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next    = in_item;
                    addr_next    = '0;
                    pend_next    = 1'b0;
                    match_next   = 1'b0;
                    free_next    = 1'b0;
                    removed_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next     = issue;
                pend_idx_next = addr_reg[IDX_W-1:0];
                if (issue) begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    if (item_reg.command == CMD_SWEEP) begin
                        if (cur_valid && (age > recycle_time)) begin
                            valid_next[pend_idx_reg] = 1'b0;
                            removed_next = removed_reg + CNT_W'(1);
                        end
                    end else begin
                        if (cur_valid && (ram_rdata.key == item_reg.key) && !match_reg) begin
                            match_next      = 1'b1;
                            match_idx_next  = pend_idx_reg;
                            match_user_next = ram_rdata.user;
                        end
                        if (!cur_valid && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                    end
                end
                if (!issue && !pend_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                case (item_reg.command)
                    CMD_ADD: begin
                        res.hit = match_reg;
                        if (match_reg) begin
                            ram_req.we = res_ready;
                        end else if (free_reg) begin
                            ram_req.we    = res_ready;
                            ram_req.waddr = free_idx_reg;
                            res_count     = count_reg + CNT_W'(1);
                            if (res_ready) begin
                                valid_next[free_idx_reg] = 1'b1;
                            end
                        end else begin
                            res.status = 1'b1;
                        end
                    end
                    CMD_TOUCH: begin
                        res.hit            = match_reg;
                        ram_req.we         = match_reg && res_ready;
                        ram_req.wdata.user = match_user_reg;
                    end
                    CMD_DELETE: begin
                        res.hit = match_reg;
                        if (match_reg) begin
                            res_count   = count_reg - CNT_W'(1);
                            res_removed = CNT_W'(1);
                            if (res_ready) begin
                                valid_next[match_idx_reg] = 1'b0;
                            end
                        end
                    end
                    CMD_SWEEP: begin
                        res_count   = count_reg - removed_reg;
                        res_removed = removed_reg;
                    end
                    default: begin
                    end
                endcase
                if (res_ready) begin
                    count_next = res_count;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res.occupied = fit_field(res_count);
        res.removed  = fit_field(res_removed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            addr_reg    <= '0;
            pend_reg    <= 1'b0;
            match_reg   <= 1'b0;
            free_reg    <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            removed_reg <= '0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            pend_reg    <= pend_next;
            match_reg   <= match_next;
            free_reg    <= free_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        pend_idx_reg   <= pend_idx_next;
        match_idx_reg  <= match_idx_next;
        match_user_reg <= match_user_next;
        free_idx_reg   <= free_idx_next;
    end

endmodule

// ===== dv/tb_session_table_with_aging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_table_with_aging
// Self-checking bench for the session table with idle timeout. A driver pulls
// commands from a queue and offers them in random bursts. A monitor replays
// every accepted command on a local copy of the table and checks each result
// transfer in order. The recycle time is rewritten between phases, including
// zero and all ones. The receiver stalls randomly and holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_session_table_with_aging;

    import sta_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int KEY_POOL       = 24;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    sta_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    sta_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    session_table_with_aging uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // local copy of the table
    logic              tbl_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]  tbl_key   [TABLE_ENTRIES];
    logic [USER_W-1:0] tbl_user  [TABLE_ENTRIES];
    logic [TIME_W-1:0] tbl_stamp [TABLE_ENTRIES];
    logic [4:0]        tbl_count;
    logic [31:0]       recycle_time;

    sta_in_t     cmd_queue [$];
    sta_out_t    due_results [$];
    logic [31:0] wall_clock;
    logic        s_taken   = 1'b0;
    logic        cfg_taken = 1'b0;
    int          fail_count   = 0;
    int          results_seen = 0;

    task automatic run_session_cmd(input sta_in_t c, output sta_out_t r);
        int          slot;
        int          i;
        logic [4:0]  gone;
        logic [31:0] age;
        slot = -1;
        gone = '0;
        r    = '0;
        if (c.command != CMD_SWEEP) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && tbl_valid[i] && tbl_key[i] == c.key) slot = i;
        end
        case (c.command)
            CMD_ADD: begin
                if (slot >= 0) begin
                    r.hit           = 1'b1;
                    tbl_user[slot]  = c.user_id;
                    tbl_stamp[slot] = c.now;
                end else begin
                    for (i = 0; i < TABLE_ENTRIES; i++)
                        if (slot < 0 && !tbl_valid[i]) slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot]   = c.key;
                        tbl_user[slot]  = c.user_id;
                        tbl_stamp[slot] = c.now;
                        tbl_count++;
                    end else begin
                        r.status = 1'b1;
                    end
                end
            end
            CMD_TOUCH: begin
                if (slot >= 0) begin
                    r.hit           = 1'b1;
                    tbl_stamp[slot] = c.now;
                end
            end
            CMD_DELETE: begin
                if (slot >= 0) begin
                    r.hit           = 1'b1;
                    tbl_valid[slot] = 1'b0;
                    tbl_count--;
                    gone = 5'd1;
                end
            end
            default: begin
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    age = c.now - tbl_stamp[i];
                    if (tbl_valid[i] && age > recycle_time) begin
                        tbl_valid[i] = 1'b0;
                        tbl_count--;
                        gone++;
                    end
                end
            end
        endcase
        r.occupied = tbl_count;
        r.removed  = gone;
    endtask

    // monitor: config, command and result transfers
    always @(posedge aclk) begin
        sta_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            tbl_count    = '0;
            recycle_time = 32'd60;
            s_taken   <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            s_taken   <= s_valid && s_ready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_data.hit);
                        fail_count++;
                    end
                    if (m_data.occupied !== want.occupied) begin
                        $error("occupied: expected %0d, actual %0d",
                               want.occupied, m_data.occupied);
                        fail_count++;
                    end
                    if (m_data.removed !== want.removed) begin
                        $error("removed: expected %0d, actual %0d",
                               want.removed, m_data.removed);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) recycle_time = cfg_data;
            if (s_valid && s_ready) begin
                run_session_cmd(s_data, want);
                due_results.push_back(want);
            end
        end
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                s_data  <= cmd_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 16);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall modes plus one long hold-off
    int   rx_mode   = 0;
    int   mode_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 100) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL session_table_with_aging");
            $finish;
        end
    end

    task automatic queue_cmd(input cmd_t c, input logic [15:0] k, input logic [31:0] u,
                             input logic [31:0] t);
        sta_in_t item;
        item.command = c;
        item.key     = k;
        item.user_id = u;
        item.now     = t;
        cmd_queue.push_back(item);
    endtask

    task automatic queue_random(input int count, input int unsigned max_step);
        logic [15:0] pool [KEY_POOL];
        sta_in_t     item;
        int unsigned r;
        for (int n = 0; n < KEY_POOL; n++) pool[n] = 16'($urandom);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)      item.command = CMD_ADD;
            else if (r < 65) item.command = CMD_TOUCH;
            else if (r < 82) item.command = CMD_DELETE;
            else             item.command = CMD_SWEEP;
            item.key = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                    : pool[$urandom_range(0, KEY_POOL-1)];
            item.user_id = $urandom;
            if ($urandom_range(0, 63) == 0) wall_clock = $urandom;
            else wall_clock = wall_clock + $urandom_range(0, max_step);
            item.now = wall_clock;
            cmd_queue.push_back(item);
        end
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || s_valid || due_results.size() != 0)
            @(negedge aclk);
        repeat (24) @(negedge aclk);
    endtask

    task automatic write_recycle(input logic [31:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, absent keys, fill to full, refresh, wrap, sweep
        queue_cmd(CMD_SWEEP, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        queue_cmd(CMD_TOUCH, 16'h1234, 32'd0, 32'd1);
        queue_cmd(CMD_DELETE, 16'h1234, 32'd0, 32'd2);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            queue_cmd(CMD_ADD, (i == 15) ? 16'hFFFF : 16'(i * 257),
                      (i == 15) ? 32'hFFFF_FFFF : 32'(i),
                      (i == 0) ? 32'hFFFF_FFF0 : 32'(i * 8));
        queue_cmd(CMD_ADD, 16'hBEEF, 32'h5555_AAAA, 32'd130);
        queue_cmd(CMD_ADD, 16'h0000, 32'hFFFF_FFFF, 32'd200);
        queue_cmd(CMD_TOUCH, 16'hFFFF, 32'd0, 32'd200);
        queue_cmd(CMD_DELETE, 16'h0303, 32'd0, 32'd140);
        queue_cmd(CMD_ADD, 16'hBEEF, 32'hAAAA_5555, 32'd150);
        queue_cmd(CMD_SWEEP, 16'h0000, 32'd0, 32'd200);
        wall_clock = $urandom;

        queue_random(200, 3);
        write_recycle(32'd0);
        queue_random(200, 3);
        write_recycle(32'hFFFF_FFFF);
        queue_random(250, 1000);
        write_recycle($urandom_range(1, 300));
        queue_random(300, 40);
        write_recycle($urandom);
        queue_random(200, 32'hFFFF_FFFF);
        write_recycle(32'd1);
        queue_random(150, 3);

        wait_idle();
        repeat (40) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS session_table_with_aging");
        else
            $display("FAIL session_table_with_aging");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sta_pkg.sv
hw/rtl/sta_ram.sv
hw/rtl/sta_ctrl.sv
hw/rtl/session_table_with_aging.sv
dv/tb_session_table_with_aging.sv
